### rtl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked at every rising clock edge outside reset.
`define ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
	else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
	else $error("assertion failed");
`endif

### rtl/asb_pkg.sv
`timescale 1ns / 1ps
package asb_pkg;
	// Register indexes of the configuration port.
	localparam logic [2:0] REG_MODE  = 3'd0;
	localparam logic [2:0] REG_SX    = 3'd1;
	localparam logic [2:0] REG_SY    = 3'd2;
	localparam logic [2:0] REG_EX    = 3'd3;
	localparam logic [2:0] REG_EY    = 3'd4;
	localparam logic [2:0] REG_SIZE  = 3'd5;
	localparam logic [2:0] REG_INNER = 3'd6;
	localparam logic [2:0] REG_COLOR = 3'd7;

	localparam int NUM_CELLS = 16;

	// Shape description shared by every coverage cell.
	typedef struct packed {
		logic               mode;
		logic signed [14:0] ax;
		logic signed [14:0] ay;
		logic signed [14:0] bx;
		logic signed [14:0] by;
		logic        [10:0] r8;
		logic        [7:0]  inner;
	} shape_t;

	// Word travelling down the chain of cells.
	typedef struct packed {
		logic        vld;
		logic        skip;
		logic [8:0]  px;
		logic [7:0]  py;
		logic [15:0] old;
		logic [4:0]  cnt;
	} tok_t;

	// Subsample offset in eighths for index 0..3.
	function automatic logic signed [2:0] sub_off(input logic [1:0] i);
		case (i)
			2'd0: sub_off = -3'sd3;
			2'd1: sub_off = -3'sd1;
			2'd2: sub_off = 3'sd1;
			default: sub_off = 3'sd3;
		endcase
	endfunction
endpackage

### rtl/asb_cell.sv
`timescale 1ns / 1ps
// One subsample test, spread over four registered steps: differences,
// products, the square of the cross product, and the final compare. The
// token moves through in lock step with the chain's stall.
module asb_cell #(
	parameter logic [3:0] IDX = 4'd0
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  asb_pkg::shape_t shp,
	input  asb_pkg::tok_t   tin,
	output asb_pkg::tok_t   tout
);
	localparam logic [1:0] SXI = IDX[1:0];
	localparam logic [1:0] SYI = IDX[3:2];

	asb_pkg::tok_t t_s1, t_s2, t_s3;
	logic signed [15:0] wx_s1, wy_s1, ex_s1, ey_s1, vx_s1, vy_s1;
	logic signed [32:0] ww_s2, ee_s2, proj_s2, len_s2, cr_s2;
	logic        [21:0] rsq_s2;
	logic signed [32:0] ww_s3, ee_s3, proj_s3, len_s3;
	logic        [65:0] crsq_s3;
	logic        [21:0] rsq_s3;
	logic        [21:0] isq_s3;

	logic signed [15:0] sx, sy;
	logic        [52:0] rl_s3;
	logic               hit;

	// Sample position in eighths.
	always_comb begin
		sx = 16'(signed'({1'b0, tin.px}) * 16'sd8) + 16'(asb_pkg::sub_off(SXI));
		sy = 16'(signed'({1'b0, tin.py}) * 16'sd8) + 16'(asb_pkg::sub_off(SYI));
	end

	// Token stages and arithmetic steps; the count is updated in the last one.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			t_s1    <= '0;
			t_s2    <= '0;
			t_s3    <= '0;
			tout    <= '0;
			wx_s1   <= '0;
			wy_s1   <= '0;
			ex_s1   <= '0;
			ey_s1   <= '0;
			vx_s1   <= '0;
			vy_s1   <= '0;
			ww_s2   <= '0;
			ee_s2   <= '0;
			proj_s2 <= '0;
			len_s2  <= '0;
			cr_s2   <= '0;
			rsq_s2  <= '0;
			ww_s3   <= '0;
			ee_s3   <= '0;
			proj_s3 <= '0;
			len_s3  <= '0;
			crsq_s3 <= '0;
			rsq_s3  <= '0;
			isq_s3  <= '0;
		end else if (en) begin
			t_s1 <= tin;
			t_s2 <= t_s1;
			t_s3 <= t_s2;
			tout <= {t_s3.vld, t_s3.skip, t_s3.px, t_s3.py, t_s3.old,
				t_s3.cnt + {4'd0, hit}};
			// Differences.
			wx_s1 <= sx - 16'(shp.ax);
			wy_s1 <= sy - 16'(shp.ay);
			ex_s1 <= sx - 16'(shp.bx);
			ey_s1 <= sy - 16'(shp.by);
			vx_s1 <= 16'(shp.bx) - 16'(shp.ax);
			vy_s1 <= 16'(shp.by) - 16'(shp.ay);
			// Products.
			ww_s2   <= 33'(wx_s1 * wx_s1) + 33'(wy_s1 * wy_s1);
			ee_s2   <= 33'(ex_s1 * ex_s1) + 33'(ey_s1 * ey_s1);
			proj_s2 <= 33'(wx_s1 * vx_s1) + 33'(wy_s1 * vy_s1);
			len_s2  <= 33'(vx_s1 * vx_s1) + 33'(vy_s1 * vy_s1);
			cr_s2   <= 33'(wx_s1 * vy_s1) - 33'(wy_s1 * vx_s1);
			rsq_s2  <= 22'(shp.r8 * shp.r8);
			// Square of the cross product; the other terms are delayed to match.
			ww_s3   <= ww_s2;
			ee_s3   <= ee_s2;
			proj_s3 <= proj_s2;
			len_s3  <= len_s2;
			crsq_s3 <= 66'(cr_s2 * cr_s2);
			rsq_s3  <= rsq_s2;
			isq_s3  <= 22'({shp.inner, 3'd0} * {shp.inner, 3'd0});
		end
	end

	// Final compare for the selected shape.
	always_comb begin
		rl_s3 = 53'(rsq_s3) * 53'(len_s3[32:0]);
		if (t_s3.skip) begin
			hit = 1'b0;
		end else if (shp.mode) begin
			hit = (ww_s3 <= 33'(rsq_s3)) && (shp.inner == 8'd0 || ww_s3 >= 33'(isq_s3));
		end else if (proj_s3 <= 0 || len_s3 == 0) begin
			hit = ww_s3 <= 33'(rsq_s3);
		end else if (proj_s3 >= len_s3) begin
			hit = ee_s3 <= 33'(rsq_s3);
		end else begin
			hit = crsq_s3 <= 66'(rl_s3);
		end
	end
endmodule

### rtl/asb_blend.sv
`timescale 1ns / 1ps
// Alpha from coverage and per-channel blend, two registered steps.
module asb_blend (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic [15:0]   color,
	input  asb_pkg::tok_t tin,
	output logic          vld,
	output logic [15:0]   new_color,
	output logic [4:0]    coverage
);
	logic        v_s1;
	logic [7:0]  al_s1;
	logic [4:0]  cnt_s1;
	logic [15:0] old_s1;
	logic [13:0] r_s1, g_s1, b_s1;
	logic [7:0]  al;
	logic [4:0]  cnt;
	logic [5:0]  rq, gq, bq;

	// Division by 255 with the usual add-and-shift form, exact for quotients below 64.
	function automatic logic [5:0] div255(input logic [13:0] v);
		logic [15:0] t;
		t = 16'(v) + 16'd1;
		t = t + (t >> 8);
		div255 = t[13:8];
	endfunction

	always_comb begin
		cnt = tin.skip ? 5'd0 : tin.cnt;
		al  = 8'((12'(cnt) * 12'd255 + 12'd8) >> 4);
	end

	// Channel quotients of the blended sums.
	always_comb begin
		rq = div255(r_s1);
		gq = div255(g_s1);
		bq = div255(b_s1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			vld  <= 1'b0;
		end else if (en) begin
			v_s1 <= tin.vld;
			vld  <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			al_s1  <= al;
			cnt_s1 <= cnt;
			old_s1 <= tin.old;
			r_s1 <= 14'(color[15:11] * al) + 14'(tin.old[15:11] * (8'd255 - al)) + 14'd127;
			g_s1 <= 14'(color[10:5] * al) + 14'(tin.old[10:5] * (8'd255 - al)) + 14'd127;
			b_s1 <= 14'(color[4:0] * al) + 14'(tin.old[4:0] * (8'd255 - al)) + 14'd127;
			coverage <= cnt_s1;
			if (al_s1 == 8'd0) begin
				new_color <= old_s1;
			end else if (al_s1 == 8'd255) begin
				new_color <= color;
			end else begin
				new_color <= {rq[4:0], gq, bq[4:0]};
			end
		end
	end
endmodule

### rtl/antialiased_shape_pixel_blender.sv
`timescale 1ns / 1ps
// Pipeline: 16 cells of 4 stages, blend of 2 stages, output register of 1.
// Throughput: one pixel per cycle while the skid register is empty; the whole
// chain, the row of sixteen subsample cells included, advances together. The
// skid register lets input run while one word waits at the output.
// Reset: arst_n clears all valid flags and configuration registers to zero.
module antialiased_shape_pixel_blender #(
	parameter int SCREEN_WIDTH  = 320,
	parameter int SCREEN_HEIGHT = 240
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [39:0] s_axis_tdata,  // pixel_x[8:0], pixel_y[16:9], old_color[32:17]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata,  // new_color[15:0], coverage[20:16]
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data
);
	logic        mode_q;
	logic [10:0] sx_q, sy_q, ex_q, ey_q;
	logic [7:0]  size_q, inner_q;
	logic [15:0] color_q;
	asb_pkg::shape_t shp;
	asb_pkg::tok_t   chain [0:asb_pkg::NUM_CELLS];
	logic        en, bvld;
	logic [15:0] bcol;
	logic [4:0]  bcov;
	logic        skid_q;
	logic [20:0] skid_data_q;
	logic        out_q;
	logic [20:0] out_data_q;

	assign cfg_ready = 1'b1;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= 1'b0; sx_q <= '0; sy_q <= '0; ex_q <= '0; ey_q <= '0;
			size_q <= '0; inner_q <= '0; color_q <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				asb_pkg::REG_MODE:  mode_q  <= cfg_data[0];
				asb_pkg::REG_SX:    sx_q    <= cfg_data[10:0];
				asb_pkg::REG_SY:    sy_q    <= cfg_data[10:0];
				asb_pkg::REG_EX:    ex_q    <= cfg_data[10:0];
				asb_pkg::REG_EY:    ey_q    <= cfg_data[10:0];
				asb_pkg::REG_SIZE:  size_q  <= cfg_data[7:0];
				asb_pkg::REG_INNER: inner_q <= cfg_data[7:0];
				asb_pkg::REG_COLOR: color_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Shape in eighths; in circle mode both ends sit at the centre and the cell tests the distance from it.
	always_comb begin
		shp.mode  = mode_q;
		shp.ax    = 15'(signed'(sx_q)) * 15'sd8;
		shp.ay    = 15'(signed'(sy_q)) * 15'sd8;
		shp.bx    = mode_q ? shp.ax : 15'(signed'(ex_q)) * 15'sd8;
		shp.by    = mode_q ? shp.ay : 15'(signed'(ey_q)) * 15'sd8;
		shp.r8    = mode_q ? {size_q, 3'b0} : {1'b0, size_q, 2'b0};
		shp.inner = inner_q;
	end

	// The whole chain moves unless the skid register is full.
	assign en = !skid_q;
	assign s_axis_tready = en;

	always_comb begin
		chain[0].vld  = s_axis_tvalid;
		chain[0].px   = s_axis_tdata[8:0];
		chain[0].py   = s_axis_tdata[16:9];
		chain[0].old  = s_axis_tdata[32:17];
		chain[0].cnt  = 5'd0;
		chain[0].skip = (32'(s_axis_tdata[8:0]) >= 32'(SCREEN_WIDTH)) ||
			(32'(s_axis_tdata[16:9]) >= 32'(SCREEN_HEIGHT)) || (size_q == 8'd0);
	end

	// Row of subsample cells.
	for (genvar i = 0; i < asb_pkg::NUM_CELLS; i++) begin : g_cell
		asb_cell #(.IDX(4'(i))) u_cell (
			.clk(clk), .arst_n(arst_n), .en(en), .shp(shp),
			.tin(chain[i]), .tout(chain[i+1])
		);
	end

	asb_blend u_blend (
		.clk(clk), .arst_n(arst_n), .en(en), .color(color_q),
		.tin(chain[asb_pkg::NUM_CELLS]), .vld(bvld), .new_color(bcol), .coverage(bcov)
	);

	// Output register with skid register behind it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_q  <= 1'b0;
			skid_q <= 1'b0;
		end else begin
			if (!out_q || m_axis_tready) begin
				out_q  <= skid_q || (bvld && en);
				skid_q <= 1'b0;
			end else if (bvld && en) begin
				skid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!out_q || m_axis_tready) begin
			out_data_q <= skid_q ? skid_data_q : {bcov, bcol};
		end else if (bvld && en) begin
			skid_data_q <= {bcov, bcol};
		end
	end

	assign m_axis_tvalid = out_q;
	assign m_axis_tdata  = {3'd0, out_data_q};
endmodule

### rtl/asb_checker.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
// Port-level checks on the blender.
module asb_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tready,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [23:0] m_axis_tdata
);
	`ASSERT_IMP(a_cov_range, clk, arst_n, m_axis_tvalid, m_axis_tdata[20:16] <= 5'd16)
	`ASSERT_IMP(a_pad_zero, clk, arst_n, m_axis_tvalid, m_axis_tdata[23:21] == 3'd0)
	`ASSERT_NXT(a_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
	`ASSERT_NXT(a_data_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata))
	`ASSERT_IMP(a_ready_empty, clk, arst_n, !m_axis_tvalid, s_axis_tready)
endmodule

bind antialiased_shape_pixel_blender asb_checker u_asb_checker (
	.clk(clk), .arst_n(arst_n),
	.s_axis_tready(s_axis_tready), .m_axis_tvalid(m_axis_tvalid),
	.m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata)
);

### test/antialiased_shape_pixel_blender_tb.sv
`timescale 1ns / 1ps
module antialiased_shape_pixel_blender_tb;
	localparam int SCR_W = 320;
	localparam int SCR_H = 240;
	localparam int LATENCY = 67;
	localparam int WATCHDOG_LIMIT = 20000;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [39:0] s_axis_tdata;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [23:0] m_axis_tdata;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [2:0]  cfg_index;
	logic [15:0] cfg_data;

	typedef struct packed {
		logic [8:0]  px;
		logic [7:0]  py;
		logic [15:0] old;
	} pixel_t;

	typedef struct packed {
		logic [15:0] color;
		logic [4:0]  cov;
	} blend_t;

	// Shadow copy of the shape registers.
	logic        sh_mode;
	logic [10:0] sh_sx, sh_sy, sh_ex, sh_ey;
	logic [7:0]  sh_size, sh_inner;
	logic [15:0] sh_color;

	pixel_t pixel_queue[$];
	blend_t blend_queue[$];

	int  mismatches;
	int  words_in;
	int  words_out;
	int  idle_cycles;
	bit  in_taken;
	bit  src_idle_en;
	bit  sink_idle_en;
	bit  sink_holdoff_req;
	int  holdoff_left;

	antialiased_shape_pixel_blender DUT (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	// Capsule membership test on eighth-pixel coordinates.
	function automatic bit capsule_hit(longint px, longint py, longint ax, longint ay,
		longint bx, longint by, longint rsq);
		longint vx, vy, wx, wy, len, proj, ex, ey, cr;
		vx = bx - ax;
		vy = by - ay;
		wx = px - ax;
		wy = py - ay;
		len = vx * vx + vy * vy;
		proj = wx * vx + wy * vy;
		if (proj <= 0 || len == 0)
			return wx * wx + wy * wy <= rsq;
		if (proj >= len) begin
			ex = px - bx;
			ey = py - by;
			return ex * ex + ey * ey <= rsq;
		end
		cr = wx * vy - wy * vx;
		return cr * cr <= rsq * len;
	endfunction

	function automatic int mix(int a, int b, int alpha);
		return (a * alpha + b * (255 - alpha) + 127) / 255;
	endfunction

	// Works out the blended colour and subsample count of one pixel.
	function automatic blend_t predict_word(pixel_t p);
		blend_t res;
		longint offs[4];
		longint ax, ay, bx, by, rsq, osq, isq, dx, dy, d;
		int cov, alpha, r, g, b;
		offs = '{-3, -1, 1, 3};
		res.color = p.old;
		res.cov = 5'd0;
		cov = 0;
		if (p.px >= SCR_W || p.py >= SCR_H || sh_size == 0)
			return res;
		ax = longint'($signed(sh_sx)) * 8;
		ay = longint'($signed(sh_sy)) * 8;
		bx = longint'($signed(sh_ex)) * 8;
		by = longint'($signed(sh_ey)) * 8;
		rsq = (longint'(sh_size) * 4) ** 2;
		osq = (longint'(sh_size) * 8) ** 2;
		isq = (longint'(sh_inner) * 8) ** 2;
		for (int sy = 0; sy < 4; sy++) begin
			for (int sx = 0; sx < 4; sx++) begin
				if (!sh_mode) begin
					if (capsule_hit(longint'(p.px) * 8 + offs[sx], longint'(p.py) * 8 + offs[sy],
						ax, ay, bx, by, rsq))
						cov++;
				end else begin
					dx = (longint'(p.px) * 8 - ax) + offs[sx];
					dy = (longint'(p.py) * 8 - ay) + offs[sy];
					d = dx * dx + dy * dy;
					if (d <= osq && (sh_inner == 0 || d >= isq))
						cov++;
				end
			end
		end
		alpha = (cov * 255 + 8) >> 4;
		if (alpha == 255) begin
			res.color = sh_color;
		end else if (alpha != 0) begin
			r = mix(sh_color[15:11], p.old[15:11], alpha);
			g = mix(sh_color[10:5], p.old[10:5], alpha);
			b = mix(sh_color[4:0], p.old[4:0], alpha);
			res.color = {r[4:0], g[5:0], b[4:0]};
		end
		res.cov = cov[4:0];
		return res;
	endfunction

	// Input monitor: takes each accepted pixel off the queue and predicts its word.
	always @(posedge clk) begin
		if (arst_n && s_axis_tvalid && s_axis_tready) begin
			blend_queue.push_back(predict_word(pixel_queue.pop_front()));
			words_in++;
			in_taken <= 1'b1;
		end else begin
			in_taken <= 1'b0;
		end
	end

	// Driver: presents queued pixels and holds each one until it is taken.
	always @(negedge clk) begin
		if (arst_n) begin
			if (s_axis_tvalid && !in_taken) begin
				s_axis_tvalid <= 1'b1;
			end else if (pixel_queue.size() > 0 && !(src_idle_en && $urandom_range(99) < 18)) begin
				s_axis_tvalid <= 1'b1;
				s_axis_tdata <= {7'd0, pixel_queue[0].old, pixel_queue[0].py, pixel_queue[0].px};
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	// Receiver ready, with random stalls and a single long hold-off on request.
	always @(negedge clk) begin
		if (holdoff_left > 0) begin
			holdoff_left <= holdoff_left - 1;
			m_axis_tready <= 1'b0;
		end else if (sink_holdoff_req) begin
			sink_holdoff_req <= 1'b0;
			holdoff_left <= 300;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= !(sink_idle_en && $urandom_range(99) < 18);
		end
	end

	// Monitor: compares each result word with the oldest prediction.
	always @(posedge clk) begin
		blend_t got, want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got.color = m_axis_tdata[15:0];
			got.cov = m_axis_tdata[20:16];
			words_out++;
			if (blend_queue.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected word: colour %h coverage %0d", got.color, got.cov);
			end else begin
				want = blend_queue.pop_front();
				if (got.color !== want.color || got.cov !== want.cov) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: colour %h/%h coverage %0d/%0d (expected/actual)",
							want.color, got.color, want.cov, got.cov);
				end
			end
		end
	end

	// Watchdog on cycles without any accepted word.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
				|| (cfg_valid && cfg_ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("watchdog expired with %0d words outstanding", blend_queue.size());
				$display("tb: failure");
				$finish;
			end
		end
	end

	// Writes one shape register and keeps the shadow copy in step.
	task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b0;
		case (idx)
			asb_pkg::REG_MODE:  sh_mode = val[0];
			asb_pkg::REG_SX:    sh_sx = val[10:0];
			asb_pkg::REG_SY:    sh_sy = val[10:0];
			asb_pkg::REG_EX:    sh_ex = val[10:0];
			asb_pkg::REG_EY:    sh_ey = val[10:0];
			asb_pkg::REG_SIZE:  sh_size = val[7:0];
			asb_pkg::REG_INNER: sh_inner = val[7:0];
			asb_pkg::REG_COLOR: sh_color = val;
			default: ;
		endcase
	endtask

	task automatic set_shape(input bit mode, input int sx, input int sy, input int ex,
		input int ey, input int size, input int inner, input int colour);
		write_reg(asb_pkg::REG_MODE, 16'(mode));
		write_reg(asb_pkg::REG_SX, 16'(sx));
		write_reg(asb_pkg::REG_SY, 16'(sy));
		write_reg(asb_pkg::REG_EX, 16'(ex));
		write_reg(asb_pkg::REG_EY, 16'(ey));
		write_reg(asb_pkg::REG_SIZE, 16'(size));
		write_reg(asb_pkg::REG_INNER, 16'(inner));
		write_reg(asb_pkg::REG_COLOR, 16'(colour));
	endtask

	// Waits for every predicted word and lets the pipeline drain.
	task automatic drain_pipeline();
		while (pixel_queue.size() > 0 || s_axis_tvalid || blend_queue.size() > 0)
			@(posedge clk);
		repeat (LATENCY + 10) @(posedge clk);
	endtask

	function automatic pixel_t near_pixel(int cx, int cy, int spread);
		pixel_t p;
		int x, y;
		x = cx + $urandom_range(2 * spread) - spread;
		y = cy + $urandom_range(2 * spread) - spread;
		p.px = (x < 0) ? 9'd0 : (x > 511) ? 9'd511 : 9'(x);
		p.py = (y < 0) ? 8'd0 : (y > 255) ? 8'd255 : 8'(y);
		p.old = 16'($urandom);
		if ($urandom_range(15) == 0)
			p.px = 9'($urandom);
		return p;
	endfunction

	// Random shapes of either kind, with bursts of pixels around them.
	task automatic random_phase(input int count);
		int cx, cy;
		if ($urandom_range(1)) begin
			cx = $urandom_range(340) - 10;
			cy = $urandom_range(260) - 10;
			set_shape(1'b1, cx, cy, $urandom_range(2047) - 1024, $urandom_range(2047) - 1024,
				$urandom_range(1, 40), ($urandom_range(2) == 0) ? 0 : $urandom_range(40),
				$urandom);
		end else begin
			cx = $urandom_range(320);
			cy = $urandom_range(240);
			set_shape(1'b0, cx, cy, cx + $urandom_range(80) - 40, cy + $urandom_range(80) - 40,
				$urandom_range(0, 12), $urandom_range(255), $urandom);
		end
		repeat (count)
			pixel_queue.push_back(near_pixel(cx, cy, 30));
		drain_pipeline();
	endtask

	initial begin
		pixel_t p;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		m_axis_tready = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = asb_pkg::REG_MODE;
		cfg_data = '0;
		{sh_mode, sh_sx, sh_sy, sh_ex, sh_ey, sh_size, sh_inner, sh_color} = '0;
		mismatches = 0;
		words_in = 0;
		words_out = 0;
		idle_cycles = 0;
		src_idle_en = 1'b0;
		sink_idle_en = 1'b0;
		sink_holdoff_req = 1'b0;
		holdoff_left = 0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Reset shape: zero size covers nothing.
		pixel_queue.push_back('{9'd10, 8'd10, 16'hABCD});
		drain_pipeline();

		// Directed: extremes, off-screen pixels, degenerate line, full coverage.
		set_shape(1'b0, 0, 0, 0, 0, 255, 0, 16'hFFFF);
		pixel_queue.push_back('{9'd0, 8'd0, 16'h0000});
		pixel_queue.push_back('{9'd319, 8'd239, 16'h1234});
		pixel_queue.push_back('{9'd320, 8'd0, 16'hFFFF});
		pixel_queue.push_back('{9'd511, 8'd255, 16'h5A5A});
		pixel_queue.push_back('{9'd0, 8'd240, 16'hA5A5});
		drain_pipeline();
		set_shape(1'b0, -1024, -1024, 1023, 1023, 1, 0, 16'hF800);
		pixel_queue.push_back('{9'd5, 8'd5, 16'h07FF});
		pixel_queue.push_back('{9'd5, 8'd6, 16'h001F});
		pixel_queue.push_back('{9'd100, 8'd101, 16'hFFFF});
		drain_pipeline();
		set_shape(1'b1, 100, 100, 0, 0, 3, 0, 16'h07E0);
		for (int i = 96; i < 105; i++)
			pixel_queue.push_back('{9'(i), 8'd100, 16'hF81F});
		drain_pipeline();
		// Ring, then inner radius above outer.
		write_reg(asb_pkg::REG_INNER, 16'd2);
		for (int i = 97; i < 104; i++)
			pixel_queue.push_back('{9'(i), 8'd101, 16'h0000});
		drain_pipeline();
		write_reg(asb_pkg::REG_INNER, 16'd255);
		pixel_queue.push_back('{9'd103, 8'd100, 16'h1111});
		drain_pipeline();
		write_reg(asb_pkg::REG_SIZE, 16'd255);
		pixel_queue.push_back('{9'd103, 8'd100, 16'h1111});
		drain_pipeline();

		// Random shapes, first with no idling at all.
		random_phase(60);
		src_idle_en = 1'b1;
		sink_idle_en = 1'b1;
		for (int n = 0; n < 10; n++) begin
			if (n == 3) begin
				// Long hold-off with enough pixels to fill the chain.
				sink_holdoff_req = 1'b1;
				random_phase(110);
			end else begin
				random_phase(50);
			end
		end
		set_shape(1'b1, 1023, -1024, 0, 0, 255, 255, 16'hFFFF);
		pixel_queue.push_back('{9'd319, 8'd0, 16'h8000});
		drain_pipeline();

		$display("covered %0d pixels over line, disc and ring shapes, off-screen and zero size",
			words_in);
		$display("with random stalls on both sides and one long output hold-off");
		if (mismatches == 0 && blend_queue.size() == 0 && words_in == words_out)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end
endmodule

### sim.f
+incdir+rtl
rtl/asb_pkg.sv
rtl/asb_cell.sv
rtl/asb_blend.sv
rtl/antialiased_shape_pixel_blender.sv
rtl/asb_checker.sv
test/antialiased_shape_pixel_blender_tb.sv
